/* rtl/d2i_pkg.sv */
`timescale 1ns / 1ps
// Package for the double-to-integer rounding unit.
// Holds field widths, operation codes and the stage payload types; no dependencies.
package d2i_pkg;

    localparam int RESULT_BITS = 62;
    localparam int OP_W        = 3;
    localparam int XARG_W      = 4;

    typedef enum logic [OP_W-1:0] {
        OP_FLOOR    = 3'd0,
        OP_CEIL     = 3'd1,
        OP_TRUNC    = 3'd2,
        OP_ROUND    = 3'd3,
        OP_EXPONENT = 3'd4
    } t_op;

    // Stage 1 to stage 2: decoded operand with the shift still to do.
    typedef struct packed {
        logic        fail;
        logic        is_exp;
        logic [2:0]  op;
        logic        neg;
        logic [52:0] sig;
        logic [11:0] exp_val;   // unbiased exponent for the exponent op
        logic        left;      // shift left (scale >= 0)
        logic [6:0]  shamt;     // shift amount, saturated at 64
    } t_dec;

    // Stage 2 to stage 3: shifted integer part and rounding information.
    typedef struct packed {
        logic        fail;
        logic        is_exp;
        logic [2:0]  op;
        logic        neg;
        logic [63:0] ip;
        logic        rem_nz;
        logic        half_up;
        logic [11:0] exp_val;
    } t_shf;

endpackage

/* rtl/d2i_decode.sv */
`timescale 1ns / 1ps
// First stage: unpacks the binary64 operand, checks the failing cases and
// computes the shift and the exponent. Depends on d2i_pkg.
module d2i_decode import d2i_pkg::*; (
    input  logic [OP_W-1:0]   i_op,
    input  logic [63:0]       i_value_bits,
    input  logic              i_is_float,
    input  logic [XARG_W-1:0] i_extra_args,
    output t_dec              o_dec
);
    logic [10:0] bexp;
    logic [51:0] frac;
    logic [5:0]  top;
    logic [12:0] scale;
    logic [12:0] nscale;

    always_comb begin
        bexp = i_value_bits[62:52];
        frac = i_value_bits[51:0];
        // Leading one of the fraction, for subnormal exponents.
        top = 6'd0;
        for (int k = 1; k < 52; k++) begin
            if (frac[k]) top = 6'(k);
        end
        if (bexp != 11'd0) scale = 13'({2'b0, bexp}) - 13'd1075;
        else               scale = -13'sd1074;
        nscale = 13'd0 - scale;

        o_dec.op      = i_op;
        o_dec.neg     = i_value_bits[63];
        o_dec.is_exp  = (i_op == OP_EXPONENT);
        o_dec.sig     = {(bexp != 11'd0), frac};
        o_dec.exp_val = (bexp != 11'd0) ? 12'({1'b0, bexp}) - 12'd1023
                                        : 12'({6'd0, top}) - 12'd1074;
        o_dec.left    = !scale[12];
        o_dec.shamt   = scale[12] ? ((nscale > 13'd64) ? 7'd64 : nscale[6:0])
                                  : scale[6:0];
        o_dec.fail    = !i_is_float || (i_extra_args != '0) || (i_op > OP_EXPONENT)
                        || (bexp == 11'h7FF)
                        || ((i_op == OP_EXPONENT) && (bexp == 11'd0) && (frac == '0))
                        || ((i_op != OP_EXPONENT)
                            && (12'(bexp) >= 12'(1023 + RESULT_BITS)));
    end
endmodule

/* rtl/d2i_shift.sv */
`timescale 1ns / 1ps
// Second stage: aligns the significand to the binary point and extracts the
// remainder flags. Depends on d2i_pkg.
module d2i_shift import d2i_pkg::*; (
    input  t_dec i_dec,
    output t_shf o_shf
);
    logic [63:0]  wide;
    logic [63:0]  rmask;
    logic [63:0]  half;
    logic [63:0]  rem;

    always_comb begin
        // Left shifts that survive the range check are at most nine places.
        wide  = {11'd0, i_dec.sig} << i_dec.shamt;
        rmask = (i_dec.shamt >= 7'd64) ? '1 : ((64'd1 << i_dec.shamt) - 64'd1);
        half  = (i_dec.shamt >= 7'd64 || i_dec.shamt == 7'd0) ? 64'd0
                : (64'd1 << (i_dec.shamt - 7'd1));
        rem   = {11'd0, i_dec.sig} & rmask;

        o_shf.fail    = i_dec.fail;
        o_shf.is_exp  = i_dec.is_exp;
        o_shf.op      = i_dec.op;
        o_shf.neg     = i_dec.neg;
        o_shf.exp_val = i_dec.exp_val;
        if (i_dec.left) begin
            o_shf.ip      = wide;
            o_shf.rem_nz  = 1'b0;
            o_shf.half_up = 1'b0;
        end else begin
            o_shf.ip      = (i_dec.shamt >= 7'd64) ? 64'd0
                            : ({11'd0, i_dec.sig} >> i_dec.shamt);
            o_shf.rem_nz  = (rem != '0);
            o_shf.half_up = (half != '0) && (rem >= half);
        end
    end
endmodule

/* rtl/d2i_round.sv */
`timescale 1ns / 1ps
// Third stage: applies the rounding increment, the range check and the sign.
// Depends on d2i_pkg.
module d2i_round import d2i_pkg::*; (
    input  t_shf                          i_shf,
    output logic                          o_failed,
    output logic signed [RESULT_BITS-1:0] o_result
);
    logic        inc;
    logic [63:0] mag;
    logic [63:0] limit;
    logic        ovf;

    always_comb begin
        case (i_shf.op)
            OP_ROUND: inc = i_shf.half_up;
            OP_FLOOR: inc = i_shf.neg && i_shf.rem_nz;
            OP_CEIL:  inc = !i_shf.neg && i_shf.rem_nz;
            default:  inc = 1'b0;
        endcase
        mag   = i_shf.ip + 64'(inc);
        limit = 64'd1 << (RESULT_BITS - 1);
        ovf   = i_shf.neg ? (mag > limit) : (mag >= limit);
        if (i_shf.fail || (!i_shf.is_exp && ovf)) begin
            o_failed = 1'b1;
            o_result = '0;
        end else if (i_shf.is_exp) begin
            o_failed = 1'b0;
            o_result = RESULT_BITS'(signed'(i_shf.exp_val));
        end else begin
            o_failed = 1'b0;
            o_result = i_shf.neg ? RESULT_BITS'(64'd0 - mag) : RESULT_BITS'(mag);
        end
    end
endmodule

/* rtl/double_to_integer_round.sv */
`timescale 1ns / 1ps
// Top level of the double-to-integer rounding unit: three-stage pipeline with
// an elastic handshake. Depends on d2i_pkg, d2i_decode, d2i_shift, d2i_round.
//
// Usage: the input channel carries one binary64 operand per transfer with an
// operation code (floor, ceiling, truncate, round half away from zero, or
// exponent). The output channel carries one transfer per input: a fail flag
// in tuser and the 62-bit two's complement result in tdata.
// A result passes through the decode, alignment and result registers in
// turn before it becomes valid. Throughput is one item per cycle while the
// receiver is ready; each stage register sits behind the decode, the
// alignment shifter and the rounding adder respectively.
// The pipeline advances as a whole whenever the output register is empty or
// taken, so a stalled receiver holds every stage in place and s_axis_tready
// falls only while the last stage holds an untaken result.
// Reset (i_rst_n low at a clock edge) clears all stage valid bits; data
// registers are not reset.
module double_to_integer_round import d2i_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // [2:0] op, [66:3] value_bits, [67] is_float,
                                       // [71:68] extra_args
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [61:0] integer_result, [63:62] zero fill
    output logic        m_axis_tuser   // [0] failed
);
    logic advance;
    logic r_v1, r_v2, r_v3;
    t_dec r_dec, n_dec;
    t_shf r_shf, n_shf;
    logic r_failed, n_failed;
    logic signed [RESULT_BITS-1:0] r_result, n_result;

    assign advance = !r_v3 || m_axis_tready;
    assign s_axis_tready = advance;

    d2i_decode u_decode (
        .i_op         (s_axis_tdata[2:0]),
        .i_value_bits (s_axis_tdata[66:3]),
        .i_is_float   (s_axis_tdata[67]),
        .i_extra_args (s_axis_tdata[71:68]),
        .o_dec        (n_dec)
    );

    d2i_shift u_shift (
        .i_dec    (r_dec),
        .o_shf    (n_shf)
    );

    d2i_round u_round (
        .i_shf    (r_shf),
        .o_failed (n_failed),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_dec    <= n_dec;
            r_shf    <= n_shf;
            r_failed <= n_failed;
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {2'b00, r_result};
    assign m_axis_tuser  = r_failed;

    // A stalled result must hold until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed while stalled");
    // A failed result carries a zero value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
        else $error("failed result not zero");
    // An accepted input reaches the output once every stage has advanced with a ready receiver.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready ##1
        m_axis_tready |=> m_axis_tvalid)
        else $error("pipeline lost an item");
endmodule
